// ----- hdl/id3v2_frame_walker_defines.svh -----
// Assertion macros for the ID3v2 frame walker.
// Used by the top level only; no other dependencies.
`ifndef ID3V2_FRAME_WALKER_DEFINES_SVH
`define ID3V2_FRAME_WALKER_DEFINES_SVH

`ifndef SYNTHESIS
// Combinational implication, checked at every clock edge out of reset
`define ID3FW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("id3fw: check failed");
// Implication that must hold on the following edge
`define ID3FW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("id3fw: check failed");
`else
`define ID3FW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ID3FW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/id3fw_pkg.sv -----
// Shared codes, frame identifiers and the frame-ID lookup for the ID3v2 frame walker.
// No dependencies.
package id3fw_pkg;

  // Event codes on the result channel
  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_ACCEPT  = 3'd1;
  localparam logic [2:0] EV_REJECT  = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_ZERO    = 3'd4;
  localparam logic [2:0] EV_OVER    = 3'd5;

  // Field codes
  localparam logic [2:0] FLD_TITLE  = 3'd0;
  localparam logic [2:0] FLD_ALBUM  = 3'd1;
  localparam logic [2:0] FLD_ARTIST = 3'd2;
  localparam logic [2:0] FLD_GENRE  = 3'd3;
  localparam logic [2:0] FLD_TRACK  = 3'd4;
  localparam logic [2:0] FLD_YEAR   = 3'd5;
  localparam logic [2:0] FLD_RDATE  = 3'd6;
  localparam logic [2:0] FLD_NONE   = 3'd7;

  // Tag header magic
  localparam logic [7:0] MAGIC_I = 8'h49;
  localparam logic [7:0] MAGIC_D = 8'h44;
  localparam logic [7:0] MAGIC_3 = 8'h33;
  localparam logic [7:0] MAX_VERSION = 8'd4;

  // Frame header geometry: old layout (v2.0-2.2) and new layout (v2.3/2.4)
  localparam logic [3:0] FH_ID_LEN_OLD   = 4'd3;
  localparam logic [3:0] FH_ID_LEN_NEW   = 4'd4;
  localparam logic [3:0] FH_LAST_SZ_OLD  = 4'd5;
  localparam logic [3:0] FH_LAST_SZ_NEW  = 4'd7;
  localparam logic [4:0] FH_LEN_OLD      = 5'd6;
  localparam logic [4:0] FH_LEN_NEW      = 5'd10;
  localparam logic [1:0] FH_TRAIL_OLD    = 2'd0;
  localparam logic [1:0] FH_TRAIL_NEW    = 2'd2;
  localparam logic [3:0] FH_PAYLOAD_SEEN = 4'd15;

  // Recognised frame IDs, three-letter
  localparam logic [31:0] ID_TT2 = 32'h0054_5432;
  localparam logic [31:0] ID_TAL = 32'h0054_414C;
  localparam logic [31:0] ID_TP1 = 32'h0054_5031;
  localparam logic [31:0] ID_TCO = 32'h0054_434F;
  localparam logic [31:0] ID_TRK = 32'h0054_524B;
  localparam logic [31:0] ID_TYE = 32'h0054_5945;
  // four-letter
  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
  localparam logic [31:0] ID_TRCK = 32'h5452_434B;
  localparam logic [31:0] ID_TYER = 32'h5459_4552;
  localparam logic [31:0] ID_TDRC = 32'h5444_5243;

  // Map a completed frame ID to its field code
  function automatic logic [2:0] lookup_field(input logic [31:0] id, input logic old_layout);
    logic [2:0] fld;
    fld = FLD_NONE;
    if (old_layout) begin
      case (id)
        ID_TT2:  fld = FLD_TITLE;
        ID_TAL:  fld = FLD_ALBUM;
        ID_TP1:  fld = FLD_ARTIST;
        ID_TCO:  fld = FLD_GENRE;
        ID_TRK:  fld = FLD_TRACK;
        ID_TYE:  fld = FLD_YEAR;
        default: fld = FLD_NONE;
      endcase
    end else begin
      case (id)
        ID_TIT2: fld = FLD_TITLE;
        ID_TALB: fld = FLD_ALBUM;
        ID_TPE1: fld = FLD_ARTIST;
        ID_TCON: fld = FLD_GENRE;
        ID_TRCK: fld = FLD_TRACK;
        ID_TYER: fld = FLD_YEAR;
        ID_TDRC: fld = FLD_RDATE;
        default: fld = FLD_NONE;
      endcase
    end
    return fld;
  endfunction

endpackage

// ----- hdl/id3v2_frame_walker.sv -----
// Channel  | Direction | Handshake           | Word
// in_      | input     | in_valid/in_ready   | data_byte, start_of_stream
// out_     | output    | out_valid/out_ready | event, field, payload byte, marks, tag info
//
// One byte per cycle: each accepted byte updates the parser state in the same cycle
// and any result lands in the output register, which is the only pipeline stage.
// in_ready is high while the output register is empty or being drained this cycle.
// Synchronous active-low reset puts the parser at the tag header and empties the output.
// A stalled out_ready holds the result and, through in_ready, stops intake.
// Depends on id3fw_pkg and id3v2_frame_walker_defines.svh.
`include "id3v2_frame_walker_defines.svh"

module id3v2_frame_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [2:0]  out_field_code,
  output logic [7:0]  out_payload_byte,
  output logic        out_first_of_frame,
  output logic        out_last_of_frame,
  output logic [28:0] out_tag_size,
  output logic [2:0]  out_tag_version
);
  import id3fw_pkg::*;

  // Parser phases
  localparam logic [2:0] PH_TAG_HDR   = 3'd0;
  localparam logic [2:0] PH_FRAME_HDR = 3'd1;
  localparam logic [2:0] PH_PAYLOAD   = 3'd2;
  localparam logic [2:0] PH_DONE_NEXT = 3'd3;
  localparam logic [2:0] PH_IDLE      = 3'd4;

  // Parser state
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [2:0]  version_r, version_nxt;
  logic [28:0] tag_rem_r, tag_rem_nxt;
  logic [31:0] frame_id_r, frame_id_nxt;
  logic [30:0] frame_len_r, frame_len_nxt;
  logic [3:0]  fhdr_idx_r, fhdr_idx_nxt;
  logic [2:0]  field_r, field_nxt;

  // State as seen by this byte (start of stream restarts from reset values)
  logic [2:0]  cur_phase;
  logic [3:0]  cur_hdr_idx;
  logic [2:0]  cur_version;
  logic [28:0] cur_tag_rem;
  logic [31:0] cur_frame_id;
  logic [30:0] cur_frame_len;
  logic [3:0]  cur_fhdr_idx;
  logic [2:0]  cur_field;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_event_r;
  logic [2:0]  out_field_r;
  logic [7:0]  out_byte_r;
  logic        out_first_r;
  logic        out_last_r;
  logic [28:0] out_size_r;
  logic [2:0]  out_ver_r;

  // Result of this byte
  logic        res_valid;
  logic [2:0]  res_event;
  logic [2:0]  res_field;
  logic [7:0]  res_byte;
  logic        res_first;
  logic        res_last;
  logic [28:0] res_size;
  logic [2:0]  res_ver;

  logic        accept;
  logic        old_layout;
  logic [3:0]  id_len;
  logic [3:0]  last_size;
  logic [4:0]  hdr_len;
  logic [1:0]  trailing;
  logic [28:0] tag_rem_dec;
  logic [30:0] frame_len_shift;
  logic [30:0] frame_len_dec;
  logic [31:0] frame_id_shift;
  logic [28:0] tag_size_full;
  logic [4:0]  fhdr_idx_inc;
  logic        hdr_reject;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Restart view
  always_comb begin
    if (in_start_of_stream) begin
      cur_phase     = PH_TAG_HDR;
      cur_hdr_idx   = '0;
      cur_version   = '0;
      cur_tag_rem   = '0;
      cur_frame_id  = '0;
      cur_frame_len = '0;
      cur_fhdr_idx  = '0;
      cur_field     = FLD_NONE;
    end else begin
      cur_phase     = phase_r;
      cur_hdr_idx   = hdr_idx_r;
      cur_version   = version_r;
      cur_tag_rem   = tag_rem_r;
      cur_frame_id  = frame_id_r;
      cur_frame_len = frame_len_r;
      cur_fhdr_idx  = fhdr_idx_r;
      cur_field     = field_r;
    end
  end

  // Layout and shared arithmetic
  assign old_layout      = cur_version < 3'd3;
  assign id_len          = old_layout ? FH_ID_LEN_OLD : FH_ID_LEN_NEW;
  assign last_size       = old_layout ? FH_LAST_SZ_OLD : FH_LAST_SZ_NEW;
  assign hdr_len         = old_layout ? FH_LEN_OLD : FH_LEN_NEW;
  assign trailing        = old_layout ? FH_TRAIL_OLD : FH_TRAIL_NEW;
  assign tag_rem_dec     = (cur_tag_rem != '0) ? cur_tag_rem - 29'd1 : cur_tag_rem;
  assign frame_len_shift = {cur_frame_len[22:0], in_data_byte};
  assign frame_len_dec   = (cur_frame_len != '0) ? cur_frame_len - 31'd1 : cur_frame_len;
  assign frame_id_shift  = {cur_frame_id[23:0], in_data_byte};
  assign tag_size_full   = cur_tag_rem | {21'd0, in_data_byte};
  assign fhdr_idx_inc    = {1'b0, cur_fhdr_idx} + 5'd1;
  assign hdr_reject      = ((cur_hdr_idx == 4'd0) && (in_data_byte != MAGIC_I)) ||
                           ((cur_hdr_idx == 4'd1) && (in_data_byte != MAGIC_D)) ||
                           ((cur_hdr_idx == 4'd2) && (in_data_byte != MAGIC_3)) ||
                           ((cur_hdr_idx == 4'd3) && (in_data_byte > MAX_VERSION));

  // Next state and result for one byte
  always_comb begin
    phase_nxt     = cur_phase;
    hdr_idx_nxt   = cur_hdr_idx;
    version_nxt   = cur_version;
    tag_rem_nxt   = cur_tag_rem;
    frame_id_nxt  = cur_frame_id;
    frame_len_nxt = cur_frame_len;
    fhdr_idx_nxt  = cur_fhdr_idx;
    field_nxt     = cur_field;
    res_valid     = 1'b0;
    res_event     = EV_PAYLOAD;
    res_field     = '0;
    res_byte      = '0;
    res_first     = 1'b0;
    res_last      = 1'b0;
    res_size      = '0;
    res_ver       = '0;

    case (cur_phase)
      PH_TAG_HDR: begin
        hdr_idx_nxt = cur_hdr_idx + 4'd1;
        if (hdr_reject) begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          res_event = EV_REJECT;
        end else if (cur_hdr_idx == 4'd3) begin
          version_nxt = in_data_byte[2:0];
        end else if (cur_hdr_idx == 4'd6) begin
          tag_rem_nxt = {in_data_byte, 21'd0};
        end else if (cur_hdr_idx == 4'd7) begin
          tag_rem_nxt = cur_tag_rem | {7'd0, in_data_byte, 14'd0};
        end else if (cur_hdr_idx == 4'd8) begin
          tag_rem_nxt = cur_tag_rem | {14'd0, in_data_byte, 7'd0};
        end else if (cur_hdr_idx >= 4'd9) begin
          // Last header byte: tag accepted, frame walk begins
          tag_rem_nxt   = tag_size_full;
          frame_id_nxt  = '0;
          frame_len_nxt = '0;
          fhdr_idx_nxt  = '0;
          field_nxt     = FLD_NONE;
          phase_nxt     = (tag_size_full == '0) ? PH_DONE_NEXT : PH_FRAME_HDR;
          res_valid     = 1'b1;
          res_event     = EV_ACCEPT;
          res_size      = tag_size_full;
          res_ver       = cur_version;
        end
      end

      PH_FRAME_HDR: begin
        fhdr_idx_nxt = fhdr_idx_inc[3:0];
        tag_rem_nxt  = tag_rem_dec;
        if (cur_fhdr_idx < id_len) begin
          // Frame ID bytes
          frame_id_nxt = frame_id_shift;
          if (fhdr_idx_inc == {1'b0, id_len}) begin
            field_nxt = lookup_field(frame_id_shift, old_layout);
          end
          if (tag_rem_dec == '0) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res_event = EV_OVER;
          end
        end else if (cur_fhdr_idx <= last_size) begin
          // Frame size bytes
          frame_len_nxt = frame_len_shift;
          if (cur_fhdr_idx == last_size) begin
            if (frame_len_shift == '0) begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res_event = EV_ZERO;
            end else if (({1'b0, frame_len_shift} + {30'd0, trailing}) >
                         {3'd0, tag_rem_dec}) begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res_event = EV_OVER;
            end else if (trailing == 2'd0) begin
              phase_nxt = PH_PAYLOAD;
            end
          end else if (tag_rem_dec == '0) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res_event = EV_OVER;
          end
        end else if (fhdr_idx_inc >= hdr_len) begin
          // Flag bytes done
          phase_nxt = PH_PAYLOAD;
        end
      end

      PH_PAYLOAD: begin
        fhdr_idx_nxt  = FH_PAYLOAD_SEEN;
        tag_rem_nxt   = tag_rem_dec;
        frame_len_nxt = frame_len_dec;
        if (frame_len_dec == '0) begin
          if (tag_rem_dec == '0) begin
            phase_nxt = PH_DONE_NEXT;
          end else begin
            phase_nxt     = PH_FRAME_HDR;
            frame_id_nxt  = '0;
            frame_len_nxt = '0;
            fhdr_idx_nxt  = '0;
            field_nxt     = FLD_NONE;
          end
        end
        if (cur_field != FLD_NONE) begin
          res_valid = 1'b1;
          res_event = EV_PAYLOAD;
          res_field = cur_field;
          res_byte  = in_data_byte;
          res_first = (cur_fhdr_idx != FH_PAYLOAD_SEEN);
          res_last  = (frame_len_dec == '0);
        end
      end

      PH_DONE_NEXT: begin
        phase_nxt = PH_IDLE;
        res_valid = 1'b1;
        res_event = EV_DONE;
      end

      default: begin
        phase_nxt = cur_phase;
      end
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG_HDR;
      hdr_idx_r   <= '0;
      version_r   <= '0;
      tag_rem_r   <= '0;
      frame_id_r  <= '0;
      frame_len_r <= '0;
      fhdr_idx_r  <= '0;
      field_r     <= FLD_NONE;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      version_r   <= version_nxt;
      tag_rem_r   <= tag_rem_nxt;
      frame_id_r  <= frame_id_nxt;
      frame_len_r <= frame_len_nxt;
      fhdr_idx_r  <= fhdr_idx_nxt;
      field_r     <= field_nxt;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= accept && res_valid;
    end
  end

  // Output register: word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_event_r <= res_event;
      out_field_r <= res_field;
      out_byte_r  <= res_byte;
      out_first_r <= res_first;
      out_last_r  <= res_last;
      out_size_r  <= res_size;
      out_ver_r   <= res_ver;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_event_r;
  assign out_field_code     = out_field_r;
  assign out_payload_byte   = out_byte_r;
  assign out_first_of_frame = out_first_r;
  assign out_last_of_frame  = out_last_r;
  assign out_tag_size       = out_size_r;
  assign out_tag_version    = out_ver_r;

  // Checks
  `ID3FW_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !in_ready)
  `ID3FW_ASSERT_NOW(a_payload_only_fields, clk, rst_n, out_valid_r && (out_event_r != EV_PAYLOAD), (out_byte_r == 8'd0) && !out_first_r && !out_last_r && (out_field_r == 3'd0))
  `ID3FW_ASSERT_NOW(a_tag_info_only_accept, clk, rst_n, out_valid_r && (out_event_r != EV_ACCEPT), (out_size_r == 29'd0) && (out_ver_r == 3'd0))
  `ID3FW_ASSERT_NOW(a_payload_len_live, clk, rst_n, phase_r == PH_PAYLOAD, frame_len_r != 31'd0)
  `ID3FW_ASSERT_NEXT(a_idle_no_result, clk, rst_n, accept && !in_start_of_stream && (phase_r == PH_IDLE), !out_valid_r)

endmodule

// ----- dv/id3fw_walk_checker.sv -----
// Checker for the ID3v2 frame walker: tracks the tag and frame walk, predicts the
// result words and compares them with what the block delivers.
// Depends on id3fw_pkg for event, field and frame-ID codes.
module id3fw_walk_checker
  import id3fw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_stream,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_event_res,
  input  logic [2:0]  out_field_code,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_first_of_frame,
  input  logic        out_last_of_frame,
  input  logic [28:0] out_tag_size,
  input  logic [2:0]  out_tag_version,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef enum logic [2:0] {
    WALK_TAG_HDR,
    WALK_FRAME_HDR,
    WALK_PAYLOAD,
    WALK_DONE_NEXT,
    WALK_IDLE
  } walk_phase_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [2:0]  fld;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [28:0] size;
    logic [2:0]  ver;
  } walk_result_t;

  // Text frames by field code, per header layout
  localparam logic [31:0] SHORT_IDS [0:5] = '{ID_TT2, ID_TAL, ID_TP1, ID_TCO, ID_TRK, ID_TYE};
  localparam logic [31:0] LONG_IDS [0:6] =
    '{ID_TIT2, ID_TALB, ID_TPE1, ID_TCON, ID_TRCK, ID_TYER, ID_TDRC};

  walk_result_t results_due[$];

  // Walk state
  walk_phase_t phase_q;
  logic [3:0]  hdr_idx;
  logic [2:0]  ver_q;
  logic [28:0] tag_left;
  logic [31:0] frame_id;
  logic [30:0] frame_len;
  logic [3:0]  fh_idx;
  logic [2:0]  frame_fld;

  function automatic logic [2:0] field_of(input logic [31:0] id, input logic old_layout);
    logic [2:0] fld;
    fld = FLD_NONE;
    if (old_layout) begin
      for (int k = 0; k < 6; k++) if (id == SHORT_IDS[k]) fld = 3'(k);
    end else begin
      for (int k = 0; k < 7; k++) if (id == LONG_IDS[k]) fld = 3'(k);
    end
    return fld;
  endfunction

  task automatic new_frame();
    frame_id  = '0;
    frame_len = '0;
    fh_idx    = '0;
    frame_fld = FLD_NONE;
  endtask

  task automatic clear_walk();
    phase_q  = WALK_TAG_HDR;
    hdr_idx  = '0;
    ver_q    = '0;
    tag_left = '0;
    new_frame();
  endtask

  task automatic due(input logic [2:0] ev, input logic [2:0] fld, input logic [7:0] data,
                     input logic first, input logic last, input logic [28:0] size,
                     input logic [2:0] ver);
    walk_result_t w;
    w = '{ev: ev, fld: fld, data: data, first: first, last: last, size: size, ver: ver};
    results_due.push_back(w);
  endtask

  // Advance the walk by one input word
  task automatic walk_byte(input logic [7:0] b, input logic sos);
    logic        old_layout, first_b, last_b;
    logic [2:0]  fld;
    logic [31:0] need;
    int          i, hdr_len, id_len, last_sz, trailing;
    if (sos) clear_walk();
    old_layout = (ver_q < 3);
    hdr_len  = old_layout ? int'(FH_LEN_OLD) : int'(FH_LEN_NEW);
    id_len   = old_layout ? int'(FH_ID_LEN_OLD) : int'(FH_ID_LEN_NEW);
    last_sz  = old_layout ? int'(FH_LAST_SZ_OLD) : int'(FH_LAST_SZ_NEW);
    trailing = old_layout ? int'(FH_TRAIL_OLD) : int'(FH_TRAIL_NEW);
    case (phase_q)
      WALK_TAG_HDR: begin
        i = int'(hdr_idx);
        hdr_idx = hdr_idx + 4'd1;
        if ((i == 0 && b != MAGIC_I) || (i == 1 && b != MAGIC_D) ||
            (i == 2 && b != MAGIC_3) || (i == 3 && b > MAX_VERSION)) begin
          phase_q = WALK_IDLE;
          due(EV_REJECT, 3'd0, 8'd0, 1'b0, 1'b0, 29'd0, 3'd0);
        end else if (i == 3) begin
          ver_q = b[2:0];
        end else if (i == 6) begin
          tag_left = {b, 21'd0};
        end else if (i == 7) begin
          tag_left |= {7'd0, b, 14'd0};
        end else if (i == 8) begin
          tag_left |= {14'd0, b, 7'd0};
        end else if (i >= 9) begin
          tag_left |= {21'd0, b};
          new_frame();
          phase_q = (tag_left == 0) ? WALK_DONE_NEXT : WALK_FRAME_HDR;
          due(EV_ACCEPT, 3'd0, 8'd0, 1'b0, 1'b0, tag_left, ver_q);
        end
      end
      WALK_FRAME_HDR: begin
        i = int'(fh_idx);
        fh_idx = fh_idx + 4'd1;
        if (tag_left != 0) tag_left = tag_left - 29'd1;
        if (i < id_len) begin
          frame_id = {frame_id[23:0], b};
          if (i + 1 == id_len) frame_fld = field_of(frame_id, old_layout);
          // tag ran out inside the frame header
          if (tag_left == 0) begin
            phase_q = WALK_IDLE;
            due(EV_OVER, 3'd0, 8'd0, 1'b0, 1'b0, 29'd0, 3'd0);
          end
        end else if (i <= last_sz) begin
          frame_len = {frame_len[22:0], b};
          if (i == last_sz) begin
            need = {1'b0, frame_len} + 32'(trailing);
            if (frame_len == 0) begin
              phase_q = WALK_IDLE;
              due(EV_ZERO, 3'd0, 8'd0, 1'b0, 1'b0, 29'd0, 3'd0);
            end else if (need > {3'd0, tag_left}) begin
              phase_q = WALK_IDLE;
              due(EV_OVER, 3'd0, 8'd0, 1'b0, 1'b0, 29'd0, 3'd0);
            end else if (trailing == 0) begin
              phase_q = WALK_PAYLOAD;
            end
          end else if (tag_left == 0) begin
            phase_q = WALK_IDLE;
            due(EV_OVER, 3'd0, 8'd0, 1'b0, 1'b0, 29'd0, 3'd0);
          end
        end else if (i + 1 >= hdr_len) begin
          phase_q = WALK_PAYLOAD;
        end
      end
      WALK_PAYLOAD: begin
        first_b = (fh_idx != FH_PAYLOAD_SEEN);
        fld = frame_fld;
        fh_idx = FH_PAYLOAD_SEEN;
        if (tag_left != 0) tag_left = tag_left - 29'd1;
        if (frame_len != 0) frame_len = frame_len - 31'd1;
        last_b = (frame_len == 0);
        if (last_b) begin
          if (tag_left == 0) begin
            phase_q = WALK_DONE_NEXT;
          end else begin
            phase_q = WALK_FRAME_HDR;
            new_frame();
          end
        end
        if (fld != FLD_NONE) due(EV_PAYLOAD, fld, b, first_b, last_b, 29'd0, 3'd0);
      end
      WALK_DONE_NEXT: begin
        phase_q = WALK_IDLE;
        due(EV_DONE, 3'd0, 8'd0, 1'b0, 1'b0, 29'd0, 3'd0);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $time, checked, what);
    fail_count++;
  endtask

  // Compare one delivered word with the oldest prediction
  task automatic check_result();
    walk_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("unexpected word, event %0d", out_event_res));
      return;
    end
    want = results_due.pop_front();
    checked++;
    if (out_event_res !== want.ev)
      report_mismatch($sformatf("event %0d, want %0d", out_event_res, want.ev));
    if (out_field_code !== want.fld)
      report_mismatch($sformatf("field %0d, want %0d", out_field_code, want.fld));
    if (out_payload_byte !== want.data)
      report_mismatch($sformatf("payload %02h, want %02h", out_payload_byte, want.data));
    if (out_first_of_frame !== want.first)
      report_mismatch($sformatf("first %0b, want %0b", out_first_of_frame, want.first));
    if (out_last_of_frame !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", out_last_of_frame, want.last));
    if (out_tag_size !== want.size)
      report_mismatch($sformatf("tag size %0h, want %0h", out_tag_size, want.size));
    if (out_tag_version !== want.ver)
      report_mismatch($sformatf("version %0d, want %0d", out_tag_version, want.ver));
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    clear_walk();
  end

  // Words are taken at the edge where both handshake lines were high
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) walk_byte(in_data_byte, in_start_of_stream);
      if (out_valid && out_ready) check_result();
    end else begin
      clear_walk();
      results_due.delete();
    end
    pending = results_due.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the ID3v2 frame walker bench: clock, reset, tag streams and back-pressure.
// Builds well-formed and damaged tags, feeds them byte by byte and gives the verdict.
// Depends on id3fw_pkg, id3v2_frame_walker and id3fw_walk_checker.
module tb_top;
  import id3fw_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_start_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_event_res;
  logic [2:0]  out_field_code;
  logic [7:0]  out_payload_byte;
  logic        out_first_of_frame;
  logic        out_last_of_frame;
  logic [28:0] out_tag_size;
  logic [2:0]  out_tag_version;

  int fail_count, pending, checked;
  int bytes_sent, tags_sent, noise_sent;
  bit gaps_on;

  logic [7:0] file_q[$];
  logic [7:0] body_q[$];

  localparam logic [31:0] SHORT_IDS [0:5] = '{ID_TT2, ID_TAL, ID_TP1, ID_TCO, ID_TRK, ID_TYE};
  localparam logic [31:0] LONG_IDS [0:6] =
    '{ID_TIT2, ID_TALB, ID_TPE1, ID_TCON, ID_TRCK, ID_TYER, ID_TDRC};

  always #10 clk = ~clk;

  id3v2_frame_walker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_start_of_stream (in_start_of_stream),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_field_code     (out_field_code),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_tag_size       (out_tag_size),
    .out_tag_version    (out_tag_version)
  );

  id3fw_walk_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_start_of_stream (in_start_of_stream),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_field_code     (out_field_code),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_tag_size       (out_tag_size),
    .out_tag_version    (out_tag_version),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked)
  );

  // Result-side stalls
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= !gaps_on || ($urandom_range(0, 99) >= 21);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom());
  endfunction

  // Offer one word, with random idle cycles ahead of it, and hold until taken
  task automatic send_byte(input logic [7:0] b, input logic sos);
    while (gaps_on && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_start_of_stream <= sos;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_file(input bit marked, input bit sos_noise);
    foreach (file_q[k])
      send_byte(file_q[k], (k == 0 && marked) ||
                           (sos_noise && k > 0 && $urandom_range(0, 24) == 0));
    file_q.delete();
  endtask

  // Tag header; the size goes out syncsafe or as overlapping full bytes
  task automatic put_tag_header(input logic [7:0] ver, input logic [28:0] size);
    file_q.push_back(MAGIC_I);
    file_q.push_back(MAGIC_D);
    file_q.push_back(MAGIC_3);
    file_q.push_back(ver);
    file_q.push_back(rand_byte());
    file_q.push_back(rand_byte());
    if (!size[28] && $urandom_range(0, 1)) begin
      file_q.push_back({1'b0, size[27:21]});
      file_q.push_back({1'b0, size[20:14]});
      file_q.push_back({1'b0, size[13:7]});
      file_q.push_back({1'b0, size[6:0]});
    end else begin
      file_q.push_back(size[28:21]);
      file_q.push_back(size[21:14]);
      file_q.push_back(size[14:7]);
      file_q.push_back(size[7:0]);
    end
  endtask

  // Header plus whatever body has been built
  task automatic compose(input logic [7:0] ver, input logic [28:0] size);
    file_q.delete();
    put_tag_header(ver, size);
    foreach (body_q[k]) file_q.push_back(body_q[k]);
    body_q.delete();
  endtask

  task automatic put_frame(input bit old_layout, input logic [31:0] id,
                           input logic [30:0] plen, input int body_len);
    if (old_layout) begin
      body_q.push_back(id[23:16]);
      body_q.push_back(id[15:8]);
      body_q.push_back(id[7:0]);
      body_q.push_back(plen[23:16]);
      body_q.push_back(plen[15:8]);
      body_q.push_back(plen[7:0]);
    end else begin
      body_q.push_back(id[31:24]);
      body_q.push_back(id[23:16]);
      body_q.push_back(id[15:8]);
      body_q.push_back(id[7:0]);
      // top size bit is dropped by the block
      body_q.push_back({1'($urandom_range(0, 1)), plen[30:24]});
      body_q.push_back(plen[23:16]);
      body_q.push_back(plen[15:8]);
      body_q.push_back(plen[7:0]);
      body_q.push_back(rand_byte());
      body_q.push_back(rand_byte());
    end
    repeat (body_len) body_q.push_back(rand_byte());
  endtask

  function automatic logic [31:0] pick_id(input bit old_layout);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom();
    if (r == 2) return old_layout ? LONG_IDS[$urandom_range(0, 6)] : SHORT_IDS[$urandom_range(0, 5)];
    return old_layout ? SHORT_IDS[$urandom_range(0, 5)] : LONG_IDS[$urandom_range(0, 6)];
  endfunction

  // Well-formed tag with random frames and a random way of ending
  task automatic random_tag();
    logic [7:0]  ver;
    logic [30:0] p;
    bit          old_layout;
    int          plen, tag_len, keep;
    ver = 8'($urandom_range(0, 4));
    old_layout = (ver < 3);
    body_q.delete();
    repeat ($urandom_range(1, 4)) begin
      plen = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      put_frame(old_layout, pick_id(old_layout), 31'(plen), plen);
    end
    tag_len = body_q.size();
    case ($urandom_range(0, 9))
      0, 1: begin
        // zero padding: zero-size stop or a cut-off frame header
        repeat ($urandom_range(1, 12)) body_q.push_back(8'h00);
        tag_len = body_q.size();
      end
      2: begin
        // frame that just fits, one byte too long, or far too long
        if ($urandom_range(0, 1)) begin
          p = 31'($urandom_range(1, 8));
          put_frame(old_layout, pick_id(old_layout), p, 0);
          tag_len = body_q.size() + int'(p) - $urandom_range(0, 1);
          repeat (int'(p)) body_q.push_back(rand_byte());
        end else begin
          p = old_layout ? 31'($urandom_range(1, 24'hFF_FFFF))
                         : 31'($urandom_range(1, 32'h7FFF_FFFF));
          put_frame(old_layout, pick_id(old_layout), p, 2);
          tag_len = body_q.size() - 2;
        end
      end
      3: begin
        tag_len = tag_len - $urandom_range(1, 5);
        if (tag_len < 1) tag_len = 1;
      end
      4: begin
        repeat ($urandom_range(1, 3)) body_q.push_back(rand_byte());
        tag_len = body_q.size();
      end
      default: ;
    endcase
    compose(ver, 29'(tag_len));
    repeat ($urandom_range(0, 2)) file_q.push_back(rand_byte());
    // now and then the next file starts early
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    send_file(1'b1, 1'b0);
    tags_sent++;
  endtask

  // Damaged or arbitrary header, random body, stray restarts
  task automatic noise_file();
    int keep;
    file_q.delete();
    file_q.push_back($urandom_range(0, 3) != 0 ? MAGIC_I : rand_byte());
    file_q.push_back($urandom_range(0, 3) != 0 ? MAGIC_D : rand_byte());
    file_q.push_back($urandom_range(0, 3) != 0 ? MAGIC_3 : rand_byte());
    file_q.push_back($urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 4)) : rand_byte());
    repeat (6) file_q.push_back(rand_byte());
    repeat ($urandom_range(0, 24)) file_q.push_back(rand_byte());
    if ($urandom_range(0, 2) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    send_file(1'b1, 1'b1);
    noise_sent++;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_data_byte       <= 8'h00;
    in_start_of_stream <= 1'b0;
    gaps_on    = 1'b1;
    bytes_sent = 0;
    tags_sent  = 0;
    noise_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty v2.4 tag with no start mark straight after reset; tag done on next word
    compose(8'd4, 29'd0);
    file_q.push_back(rand_byte());
    send_file(1'b0, 1'b0);
    // bad magic at each position, then a version above 4
    file_q = '{8'hFF};
    send_file(1'b1, 1'b0);
    file_q = '{MAGIC_I, 8'h00};
    send_file(1'b1, 1'b0);
    file_q = '{MAGIC_I, MAGIC_D, 8'h34};
    send_file(1'b1, 1'b0);
    file_q = '{MAGIC_I, MAGIC_D, MAGIC_3, 8'd5, 8'h00};
    send_file(1'b1, 1'b0);
    // largest tag size, first frame has zero size
    put_frame(1'b0, ID_TIT2, 31'd0, 0);
    compose(8'd3, 29'h1FFF_FFFF);
    file_q.push_back(8'h00);
    send_file(1'b1, 1'b0);
    // v2.2 one-byte title frame filling the tag exactly, then tag done
    put_frame(1'b1, ID_TT2, 31'd1, 1);
    compose(8'd2, 29'd7);
    file_q.push_back(8'hA5);
    send_file(1'b1, 1'b0);
    // v2.4 frame one byte too big once the flag bytes are counted
    put_frame(1'b0, ID_TPE1, 31'd3, 0);
    compose(8'd4, 29'd12);
    send_file(1'b1, 1'b0);
    // tag ends inside a frame header, then a word that is ignored
    body_q = '{8'h54, 8'h54};
    compose(8'd0, 29'd2);
    file_q.push_back(8'h54);
    send_file(1'b1, 1'b0);

    // random streams, with one long stretch free of gaps and stalls
    while (bytes_sent < 1320) begin
      gaps_on = !(bytes_sent >= 600 && bytes_sent < 800);
      if ($urandom_range(0, 4) == 0) noise_file();
      else random_tag();
    end
    gaps_on = 1'b1;
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d tags and %0d damaged streams in %0d bytes", tags_sent, noise_sent,
             bytes_sent);
    $display("checked %0d result words, %0d mismatches", checked, fail_count);
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d result words outstanding", pending);
    $display("tb_top failed");
    $finish;
  end

endmodule
